@@ rtl/ptis_pkg.sv @@
// Package for the page-table index split block: types, codes and constants.
// Used by every module of the block and by its checker. No dependencies.
package ptis_pkg;

  // Fixed widths of the data path.
  localparam int unsigned DATA_W      = 64;
  localparam int unsigned NUM_FIELDS  = 6;
  localparam int unsigned FIELD_W_W   = 7;
  localparam int unsigned CFG_DATA_W  = 42;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned LEVELS_W    = 3;
  localparam int unsigned ESIZE_W     = 4;
  // Sum of up to six field widths of up to 127 each.
  localparam int unsigned OFS_W       = 10;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEVELS    = 3'd0,
    REG_WIDTHS    = 3'd1,
    REG_CHECK     = 3'd2,
    REG_ROOT      = 3'd3,
    REG_ESZ_LOG2  = 3'd4
  } reg_idx_e;

  // Range check modes; the fourth code performs no check.
  typedef enum logic [1:0] {
    CHK_NONE     = 2'd0,
    CHK_UNSIGNED = 2'd1,
    CHK_SIGNED   = 2'd2
  } check_mode_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_ROOT = 2'd1,
    ST_TOO_BIG = 2'd2
  } status_e;

  // Configuration register contents.
  typedef struct packed {
    logic [LEVELS_W-1:0]                       levels;
    logic [NUM_FIELDS-1:0][FIELD_W_W-1:0]      widths;
    check_mode_e                               check_mode;
    logic                                      root_present;
    logic [1:0]                                esz_log2;
  } cfg_t;

  // One result item.
  typedef struct packed {
    status_e                                   status;
    logic [NUM_FIELDS-1:0][DATA_W-1:0]         idx;
    logic [DATA_W-1:0]                         rem;
    logic [LEVELS_W-1:0]                       levels;
    logic [ESIZE_W-1:0]                        esize;
  } res_t;

endpackage

@@ rtl/ptis_cfg_regs.sv @@
// Configuration register file of the page-table index split block.
// Depends on ptis_pkg for the register indexes and the cfg_t layout.
module ptis_cfg_regs
  import ptis_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Write decode; indexes beyond the list are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LEVELS:   cfg_d.levels       = cfg_wdata_i[LEVELS_W-1:0];
        REG_WIDTHS:   cfg_d.widths       = cfg_wdata_i;
        REG_CHECK:    cfg_d.check_mode   = check_mode_e'(cfg_wdata_i[1:0]);
        REG_ROOT:     cfg_d.root_present = cfg_wdata_i[0];
        REG_ESZ_LOG2: cfg_d.esz_log2     = cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/ptis_split.sv @@
// Combinational address split: field offsets, masked indices, remainder and range check.
// Depends on ptis_pkg for cfg_t, res_t and the status and check codes.
module ptis_split
  import ptis_pkg::*;
#(
  parameter int unsigned MAX_LEVELS = 6,
  parameter int unsigned ADDR_WIDTH = 64
) (
  input  cfg_t              cfg_i,
  input  logic [DATA_W-1:0] addr_i,
  output res_t              res_o
);

  localparam int unsigned LVL_LIM = (MAX_LEVELS < NUM_FIELDS) ? MAX_LEVELS : NUM_FIELDS;
  localparam logic [DATA_W-1:0] AW_MASK = {DATA_W{1'b1}} >> (DATA_W - ADDR_WIDTH);

  always_comb begin
    logic [LEVELS_W-1:0]                 n;
    logic [DATA_W-1:0]                   addr;
    logic [OFS_W-1:0]                    ofs;
    logic [DATA_W-1:0]                   idx [NUM_FIELDS];
    logic [FIELD_W_W-1:0]                w_top;
    logic [DATA_W-1:0]                   idx_top;
    logic [5:0]                          top_bit;
    logic                                sign;
    logic [DATA_W-1:0]                   rem;
    logic [DATA_W-1:0]                   expect_rem;
    status_e                             status;

    // Level count saturates at the supported limit.
    n    = (cfg_i.levels > LEVELS_W'(LVL_LIM)) ? LEVELS_W'(LVL_LIM) : cfg_i.levels;
    addr = addr_i & AW_MASK;

    // Each field is cut out at its running offset; offsets of 64 or more give zero.
    ofs     = '0;
    w_top   = '0;
    idx_top = '0;
    for (int k = 0; k < NUM_FIELDS; k++) begin
      idx[k] = '0;
      if (LEVELS_W'(k) < n) begin
        idx[k] = (addr >> ofs) & ~({DATA_W{1'b1}} << cfg_i.widths[k]);
        ofs    = ofs + OFS_W'(cfg_i.widths[k]);
        w_top  = cfg_i.widths[k];
        idx_top = idx[k];
      end
    end
    rem = addr >> ofs;

    // Sign bit of the top field; zero with no levels or a zero-width top field.
    top_bit = (w_top >= FIELD_W_W'(DATA_W)) ? 6'd63 : 6'(w_top - 1'b1);
    sign    = (w_top != '0) && idx_top[top_bit];
    if (ofs >= OFS_W'(ADDR_WIDTH)) begin
      expect_rem = '0;
    end else begin
      expect_rem = sign ? (AW_MASK >> ofs) : '0;
    end

    case (cfg_i.check_mode)
      CHK_UNSIGNED: status = (rem != '0)         ? ST_TOO_BIG : ST_OK;
      CHK_SIGNED:   status = (rem != expect_rem) ? ST_TOO_BIG : ST_OK;
      default:      status = ST_OK;
    endcase

    // Assemble the result; a missing root zeroes everything but the status.
    res_o = '0;
    if (!cfg_i.root_present) begin
      res_o.status = ST_NO_ROOT;
    end else begin
      res_o.status = status;
      for (int k = 0; k < NUM_FIELDS; k++) begin
        res_o.idx[k] = idx[k];
      end
      res_o.rem    = rem;
      res_o.levels = n;
      res_o.esize  = (n > LEVELS_W'(1)) ? (ESIZE_W'(1) << cfg_i.esz_log2) : ESIZE_W'(1);
    end
  end

endmodule

@@ rtl/page_table_index_split_core.sv @@
// Page-table index split: cuts a virtual address into per-level indices.
// Path: input register, then result register. Throughput: one address per cycle while the
// output is not stalled; the split is a single pass of parallel shifts and masks.
// While a result waits, an input is taken only if the input register is empty.
// Reset (rst_ni, async low) clears all configuration registers and both pipeline valid flags.
module page_table_index_split_core
  import ptis_pkg::*;
#(
  parameter int unsigned MAX_LEVELS = 6,
  parameter int unsigned ADDR_WIDTH = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // address input
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [DATA_W-1:0]     address_i,
  // result output
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            status_o,
  output logic [DATA_W-1:0]     index_0_o,
  output logic [DATA_W-1:0]     index_1_o,
  output logic [DATA_W-1:0]     index_2_o,
  output logic [DATA_W-1:0]     index_3_o,
  output logic [DATA_W-1:0]     index_4_o,
  output logic [DATA_W-1:0]     index_5_o,
  output logic [DATA_W-1:0]     remainder_o,
  output logic [LEVELS_W-1:0]   levels_to_walk_o,
  output logic [ESIZE_W-1:0]    element_size_o
);

  cfg_t              cfg;
  res_t              split_res;
  logic              s1_vld_q, s1_vld_d;
  logic [DATA_W-1:0] s1_addr_q;
  logic              s2_vld_q, s2_vld_d;
  res_t              s2_res_q;
  logic              s1_ld, s2_ld, out_xfer;

  ptis_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ptis_split #(
    .MAX_LEVELS (MAX_LEVELS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_split (
    .cfg_i  (cfg),
    .addr_i (s1_addr_q),
    .res_o  (split_res)
  );

  // Pipeline handshake: the result register loads from a full input register when empty or being drained.
  assign out_xfer   = s2_vld_q && !out_stall_i;
  assign s2_ld      = s1_vld_q && (!s2_vld_q || !out_stall_i);
  assign in_stall_o = s1_vld_q && !s2_ld;
  assign s1_ld      = in_valid_i && !in_stall_o;

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (s1_ld) begin
      s1_vld_d = 1'b1;
    end else if (s2_ld) begin
      s1_vld_d = 1'b0;
    end
    s2_vld_d = s2_vld_q;
    if (s2_ld) begin
      s2_vld_d = 1'b1;
    end else if (out_xfer) begin
      s2_vld_d = 1'b0;
    end
  end

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
      s2_vld_q <= s2_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s1_ld) begin
      s1_addr_q <= address_i;
    end
    if (s2_ld) begin
      s2_res_q <= split_res;
    end
  end

  assign out_valid_o      = s2_vld_q;
  assign status_o         = s2_res_q.status;
  assign index_0_o        = s2_res_q.idx[0];
  assign index_1_o        = s2_res_q.idx[1];
  assign index_2_o        = s2_res_q.idx[2];
  assign index_3_o        = s2_res_q.idx[3];
  assign index_4_o        = s2_res_q.idx[4];
  assign index_5_o        = s2_res_q.idx[5];
  assign remainder_o      = s2_res_q.rem;
  assign levels_to_walk_o = s2_res_q.levels;
  assign element_size_o   = s2_res_q.esize;

endmodule

@@ rtl/ptis_checker.sv @@
// Port-level checker for page_table_index_split_core, with its bind statement.
// Depends on ptis_pkg for widths and status codes.
module ptis_checker
  import ptis_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cfg_we_i,
  input logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic [DATA_W-1:0]     address_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [1:0]            status_o,
  input logic [DATA_W-1:0]     index_0_o,
  input logic [DATA_W-1:0]     index_1_o,
  input logic [DATA_W-1:0]     index_2_o,
  input logic [DATA_W-1:0]     index_3_o,
  input logic [DATA_W-1:0]     index_4_o,
  input logic [DATA_W-1:0]     index_5_o,
  input logic [DATA_W-1:0]     remainder_o,
  input logic [LEVELS_W-1:0]   levels_to_walk_o,
  input logic [ESIZE_W-1:0]    element_size_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A missing root gives a result that is zero but for its status.
  a_no_root_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_NO_ROOT) |->
      (index_0_o == '0) && (index_1_o == '0) && (index_2_o == '0) &&
      (index_3_o == '0) && (index_4_o == '0) && (index_5_o == '0) &&
      (remainder_o == '0) && (levels_to_walk_o == '0) && (element_size_o == '0))
    else $error("no-root result not cleared");

  // With a root, one level or less means byte-sized elements.
  a_esize_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_NO_ROOT) && (levels_to_walk_o <= 3'd1) |->
      (element_size_o == 4'd1))
    else $error("element size not 1 for a single-level walk");

  // With no levels walked, the first and last index fields are zero.
  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (levels_to_walk_o == 3'd0) |->
      (index_0_o == '0) && (index_5_o == '0))
    else $error("index present with no levels");

endmodule

bind page_table_index_split_core ptis_checker u_ptis_checker (.*);
